/* hdl/uat_escaped_frame_deframer_assert.svh */
// Assertion macros shared by the deframer checker.
// Needs nothing else; include by bare file name.
`ifndef UAT_ESCAPED_FRAME_DEFRAMER_ASSERT_SVH
`define UAT_ESCAPED_FRAME_DEFRAMER_ASSERT_SVH

// Antecedent in one cycle implies the consequent in the next, ignored in reset.
`define UEFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle rule");

// Antecedent implies the consequent in the same cycle, ignored in reset.
`define UEFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle rule");

// Next-cycle rule that also holds while reset is applied.
`define UEFD_ASSERT_NEXT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deframer check failed: reset rule");

`endif

/* hdl/uefd_pkg.sv */
// Types and constants of the escaped-frame deframer.
// No dependencies; every module file imports this package.
`timescale 1ns / 1ps

package uefd_pkg;

    localparam logic [7:0] ESC_BYTE    = 8'h1a;
    localparam logic [7:0] TYPE_SHORT  = 8'h73;
    localparam logic [7:0] TYPE_LONG   = 8'h6c;
    localparam logic [7:0] TYPE_UPLINK = 8'h75;
    localparam int unsigned STAMP_BYTES = 6;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_STAMP   = 3'd1,
        PH_SIGNAL  = 3'd2,
        PH_PAYLOAD = 3'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_BAD_TYPE = 2'd1,
        ST_BAD_ESC  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_LONG   = 2'd1,
        KIND_UPLINK = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       begins_frame;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        kind_t       frame_kind;
        logic [7:0]  payload_byte;
        logic [9:0]  byte_index;
        logic [47:0] timestamp;
        logic [7:0]  signal_byte;
        logic        signal_present;
        logic        last;
    } out_item_t;

endpackage

/* hdl/uat_escaped_frame_deframer.sv */
// Top level of the escaped-frame deframer: input register, parser, result register.
// Depends on uefd_pkg, uefd_in_reg, uefd_parser and uefd_out_reg.
`timescale 1ns / 1ps
//
//  Channel   Ports                       Direction  Carries
//  input     s_valid s_ready s_item      in         one received byte, frame-start flag
//  result    m_valid m_ready m_item      out        payload byte or error with frame info
//
//  One byte per cycle is sustained while m_ready stays high; a byte is held in the input
//  register, and its result is then loaded into the result register, from which it transfers out.
//  Reset is synchronous and clears the parse state and both valid flags.
//  A stall on the result side holds the parser and then the input register; a
//  byte that yields no result still waits until the result register can load.
//  The parse state is the only loop and it updates once per byte.

module uat_escaped_frame_deframer
    import uefd_pkg::*;
#(
    parameter int unsigned SHORT_BYTES  = 30,
    parameter int unsigned LONG_BYTES   = 48,
    parameter int unsigned UPLINK_BYTES = 552
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      held_valid;
    in_item_t  held_item;
    logic      can_take;
    logic      fire;
    logic      res_valid;
    out_item_t res;

    assign fire = held_valid && can_take;

    uefd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    uefd_parser #(
        .SHORT_BYTES  (SHORT_BYTES),
        .LONG_BYTES   (LONG_BYTES),
        .UPLINK_BYTES (UPLINK_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    uefd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && res_valid),
        .load_item (res),
        .can_take  (can_take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

/* hdl/uefd_in_reg.sv */
// Input register of the deframer: holds one received byte until parsed.
// Depends on uefd_pkg.
`timescale 1ns / 1ps

module uefd_in_reg
    import uefd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     held_valid,
    output in_item_t held_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // A new transfer is taken when the register is empty or drains this cycle.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

/* hdl/uefd_parser.sv */
// Frame parser: type decode, de-escaping, timestamp and signal capture.
// Depends on uefd_pkg.
`timescale 1ns / 1ps

module uefd_parser
    import uefd_pkg::*;
#(
    parameter int unsigned SHORT_BYTES  = 30,
    parameter int unsigned LONG_BYTES   = 48,
    parameter int unsigned UPLINK_BYTES = 552
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res
);

    localparam logic [10:0] SHORT_LEN  = 11'(SHORT_BYTES);
    localparam logic [10:0] LONG_LEN   = 11'(LONG_BYTES);
    localparam logic [10:0] UPLINK_LEN = 11'(UPLINK_BYTES);
    localparam logic [10:0] STAMP_LEN  = 11'(STAMP_BYTES);

    phase_t      phase_reg, phase_next;
    logic        esc_reg, esc_next;
    kind_t       kind_reg, kind_next;
    logic [9:0]  count_reg, count_next;
    logic [47:0] stamp_reg, stamp_next;
    logic [7:0]  signal_reg, signal_next;

    logic        active;
    logic        data_ok;
    logic        type_ok;
    kind_t       type_kind;
    logic [10:0] count_inc;
    logic [10:0] frame_len;
    logic        is_last;

    assign active = (phase_reg == PH_STAMP) || (phase_reg == PH_SIGNAL)
                 || (phase_reg == PH_PAYLOAD);
    // A data byte is either a plain byte or the second half of a doubled escape.
    assign data_ok = active && !item.begins_frame
                  && (esc_reg ? (item.rx_byte == ESC_BYTE) : (item.rx_byte != ESC_BYTE));
    assign count_inc = {1'b0, count_reg} + 11'd1;

    always_comb begin
        type_ok   = 1'b1;
        type_kind = KIND_SHORT;
        unique case (item.rx_byte)
            TYPE_SHORT:  type_kind = KIND_SHORT;
            TYPE_LONG:   type_kind = KIND_LONG;
            TYPE_UPLINK: type_kind = KIND_UPLINK;
            default:     type_ok   = 1'b0;
        endcase
    end

    always_comb begin
        case (kind_reg)
            KIND_LONG:   frame_len = LONG_LEN;
            KIND_UPLINK: frame_len = UPLINK_LEN;
            default:     frame_len = SHORT_LEN;
        endcase
    end

    assign is_last = count_inc >= frame_len;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (item.begins_frame) begin
            phase_next = type_ok ? PH_STAMP : PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_STAMP: begin
                    if (esc_reg && !data_ok) begin
                        phase_next = PH_IDLE;
                    end else if (data_ok && count_inc >= STAMP_LEN) begin
                        phase_next = PH_SIGNAL;
                    end
                end
                PH_SIGNAL: begin
                    if (esc_reg && !data_ok) begin
                        phase_next = PH_IDLE;
                    end else if (data_ok) begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if ((esc_reg && !data_ok) || (data_ok && is_last)) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Datapath updates and the result of this byte.
    always_comb begin
        esc_next    = esc_reg;
        kind_next   = kind_reg;
        count_next  = count_reg;
        stamp_next  = stamp_reg;
        signal_next = signal_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (item.begins_frame) begin
            esc_next    = 1'b0;
            count_next  = '0;
            stamp_next  = '0;
            signal_next = '0;
            kind_next   = type_kind;
            if (!type_ok) begin
                res_valid   = 1'b1;
                res.status  = ST_BAD_TYPE;
                res.last    = 1'b1;
            end
        end else if (active) begin
            if (esc_reg) begin
                esc_next = 1'b0;
                if (!data_ok) begin
                    res_valid      = 1'b1;
                    res.status     = ST_BAD_ESC;
                    res.frame_kind = kind_reg;
                    res.last       = 1'b1;
                end
            end else if (!data_ok) begin
                esc_next = 1'b1;
            end
            if (data_ok) begin
                unique case (phase_reg)
                    PH_STAMP: begin
                        stamp_next = {stamp_reg[39:0], item.rx_byte};
                        count_next = (count_inc >= STAMP_LEN) ? '0 : count_inc[9:0];
                    end
                    PH_SIGNAL: begin
                        signal_next = item.rx_byte;
                        count_next  = '0;
                    end
                    default: begin
                        res_valid          = 1'b1;
                        res.status         = ST_PAYLOAD;
                        res.frame_kind     = kind_reg;
                        res.payload_byte   = item.rx_byte;
                        res.byte_index     = count_reg;
                        res.timestamp      = stamp_reg;
                        res.signal_byte    = signal_reg;
                        res.signal_present = signal_reg != 8'd0;
                        res.last           = is_last;
                        count_next         = is_last ? '0 : count_inc[9:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            esc_reg   <= 1'b0;
            kind_reg  <= KIND_SHORT;
            count_reg <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            stamp_reg  <= stamp_next;
            signal_reg <= signal_next;
        end
    end

endmodule

/* hdl/uefd_out_reg.sv */
// Result register of the deframer, drained by the downstream handshake.
// Depends on uefd_pkg.
`timescale 1ns / 1ps

module uefd_out_reg
    import uefd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  out_item_t load_item,
    output logic      can_take,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign can_take   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= load_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

/* hdl/uefd_checker.sv */
// Port-level checks of the deframer and their binding to the top level.
// Depends on uefd_pkg and uat_escaped_frame_deframer_assert.svh.
`timescale 1ns / 1ps
`include "uat_escaped_frame_deframer_assert.svh"

module uefd_checker
    import uefd_pkg::*;
#(
    parameter int unsigned SHORT_BYTES  = 30,
    parameter int unsigned LONG_BYTES   = 48,
    parameter int unsigned UPLINK_BYTES = 552
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    localparam logic [9:0] SHORT_LAST  = 10'(SHORT_BYTES - 1);
    localparam logic [9:0] LONG_LAST   = 10'(LONG_BYTES - 1);
    localparam logic [9:0] UPLINK_LAST = 10'(UPLINK_BYTES - 1);

    logic err_res;
    logic bad_type_res;
    logic type_clean;
    logic final_pay;
    logic final_len_ok;

    assign err_res      = m_valid && (m_item.status != ST_PAYLOAD);
    assign bad_type_res = m_valid && (m_item.status == ST_BAD_TYPE);
    assign type_clean   = (m_item.timestamp == 48'd0) && (m_item.frame_kind == KIND_SHORT);
    assign final_pay    = m_valid && (m_item.status == ST_PAYLOAD) && m_item.last;
    assign final_len_ok =
        ((m_item.frame_kind == KIND_SHORT)  && (m_item.byte_index == SHORT_LAST))
     || ((m_item.frame_kind == KIND_LONG)   && (m_item.byte_index == LONG_LAST))
     || ((m_item.frame_kind == KIND_UPLINK) && (m_item.byte_index == UPLINK_LAST));

    // A stalled result transfer holds its contents.
    `UEFD_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
    // Every error result closes the frame.
    `UEFD_ASSERT_SAME(a_err_last, aclk, aresetn, err_res, m_item.last)
    // An unknown type carries no frame information.
    `UEFD_ASSERT_SAME(a_type_clean, aclk, aresetn, bad_type_res, type_clean)
    // The final payload byte sits at the end of its frame kind's length.
    `UEFD_ASSERT_SAME(a_len, aclk, aresetn, final_pay, final_len_ok)
    // Reset empties the result register.
    `UEFD_ASSERT_NEXT_RST(a_reset, aclk, !aresetn, !m_valid)

endmodule

bind uat_escaped_frame_deframer uefd_checker #(
    .SHORT_BYTES  (SHORT_BYTES),
    .LONG_BYTES   (LONG_BYTES),
    .UPLINK_BYTES (UPLINK_BYTES)
) u_uefd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
